// ----- hdl/sird_pkg.sv -----
// ---------------------------------------------------------------------------
// sird_pkg
// Shared types, constants and helpers for the signed radix digit converter.
// ---------------------------------------------------------------------------
package sird_pkg;

   localparam int VALUE_W          = 32;
   localparam int CHAR_W           = 8;
   localparam int LEN_W            = 5;
   localparam int SYM_COUNT        = 16;
   localparam int SYM_IDX_W        = 4;
   localparam int SYMS_W           = SYM_COUNT * CHAR_W;
   localparam int CSR_DATA_W       = 64;
   localparam int CSR_ADDR_W       = 5;
   localparam int MAX_BASE_DEFAULT = 16;
   // quotient bits resolved by the shared divider in one clock
   localparam int BITS_PER_STEP    = 8;

   localparam logic [LEN_W-1:0]      BASE_LEN_RESET     = 5'd10;
   localparam logic [CSR_DATA_W-1:0] SYMBOLS_LOW_RESET  = 64'h3736_3534_3332_3130;
   localparam logic [CSR_DATA_W-1:0] SYMBOLS_HIGH_RESET = 64'h0000_0000_0000_3938;

   // register index, taken from paddr[4:3]
   localparam logic [1:0] REG_BASE_LEN     = 2'd0;
   localparam logic [1:0] REG_SYMBOLS_LOW  = 2'd1;
   localparam logic [1:0] REG_SYMBOLS_HIGH = 2'd2;

   localparam logic [CHAR_W-1:0] CHAR_PLUS    = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'h00;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SIGN,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_EMIT,
      ST_NEWLINE,
      ST_ERROR
   } state_type;

   function automatic logic [CHAR_W-1:0] sym_at(input logic [SYMS_W-1:0] syms,
                                                input logic [SYM_IDX_W-1:0] idx);
      return syms[{idx, 3'b000} +: CHAR_W];
   endfunction

endpackage

// ----- hdl/sird_div.sv -----
// ---------------------------------------------------------------------------
// sird_div
// Iterative restoring divider: 32-bit dividend by a small radix, several
// quotient bits per clock.
// ---------------------------------------------------------------------------
module sird_div #(
   parameter int DIG_W = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [sird_pkg::VALUE_W-1:0] dividend,
   input  logic [DIG_W:0]               divisor,
   output logic [sird_pkg::VALUE_W-1:0] quotient,
   output logic [DIG_W-1:0]             remainder,
   output logic                         done
);

   localparam int STEPS  = sird_pkg::VALUE_W / sird_pkg::BITS_PER_STEP;
   localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

   logic [sird_pkg::VALUE_W-1:0] quo_ff, quo_in;
   logic [DIG_W-1:0]             rem_ff, rem_in;
   logic [STEP_W-1:0]            step_ff, step_in;
   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;

   logic [DIG_W:0]               part;
   logic [sird_pkg::VALUE_W-1:0] q_work;
   logic [DIG_W-1:0]             r_work;

   // shift dividend bits into the partial remainder, subtract where it fits
   always_comb begin
      r_work = rem_ff;
      q_work = quo_ff;
      part   = '0;
      for (int i = 0; i < sird_pkg::BITS_PER_STEP; i++) begin
         part   = {r_work, q_work[sird_pkg::VALUE_W-1]};
         q_work = {q_work[sird_pkg::VALUE_W-2:0], 1'b0};
         if (part >= divisor) begin
            part      = part - divisor;
            q_work[0] = 1'b1;
         end
         r_work = part[DIG_W-1:0];
      end
   end

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in  = q_work;
         rem_in  = r_work;
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule

// ----- hdl/sird_alpha.sv -----
// ---------------------------------------------------------------------------
// sird_alpha
// Alphabet validity check: length range, forbidden symbols, duplicates.
// ---------------------------------------------------------------------------
module sird_alpha #(
   parameter int MAX_BASE = sird_pkg::MAX_BASE_DEFAULT
) (
   input  logic                         clock,
   input  logic [sird_pkg::LEN_W-1:0]   base_len,
   input  logic [sird_pkg::SYMS_W-1:0]  symbols,
   output logic                         ok
);

   logic                          ok_ff, ok_in;
   logic                          bad;
   logic [sird_pkg::CHAR_W-1:0]   sym_a;

   always_comb begin
      bad   = (base_len < sird_pkg::LEN_W'(2)) ||
              (base_len > sird_pkg::LEN_W'(MAX_BASE)) ||
              (base_len > sird_pkg::LEN_W'(sird_pkg::SYM_COUNT));
      sym_a = '0;
      for (int a = 0; a < sird_pkg::SYM_COUNT; a++) begin
         sym_a = sird_pkg::sym_at(symbols, sird_pkg::SYM_IDX_W'(a));
         if (sird_pkg::LEN_W'(a) < base_len) begin
            if (sym_a == sird_pkg::CHAR_PLUS || sym_a == sird_pkg::CHAR_MINUS ||
                sym_a == sird_pkg::CHAR_SPACE) begin
               bad = 1'b1;
            end
            for (int b = a + 1; b < sird_pkg::SYM_COUNT; b++) begin
               if (sird_pkg::LEN_W'(b) < base_len &&
                   sird_pkg::sym_at(symbols, sird_pkg::SYM_IDX_W'(b)) == sym_a) begin
                  bad = 1'b1;
               end
            end
         end
      end
      ok_in = !bad;
   end

   always_ff @(posedge clock) begin
      ok_ff <= ok_in;
   end

   assign ok = ok_ff;

endmodule

// ----- hdl/signed_int_to_radix_digits.sv -----
// ---------------------------------------------------------------------------
// signed_int_to_radix_digits
// Signed 32-bit integer to text in a configurable radix and alphabet.
// ---------------------------------------------------------------------------
// Sequence: with a valid alphabet, a negative value first loads the minus sign;
//   each digit then costs the shared divider a start, four 8-bit steps and a
//   push, and is later emitted from the stack before the newline is loaded.
//   An invalid alphabet loads a NUL byte and then the newline.
// Throughput: one request at a time; ready again the cycle after the newline.
// Reset: synchronous; returns to idle, empties the output stage, restores radix 10, "0-9".
module signed_int_to_radix_digits #(
   parameter int MAX_BASE = sird_pkg::MAX_BASE_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [sird_pkg::VALUE_W-1:0] req_value,
   // result channel, one byte per beat
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [sird_pkg::CHAR_W-1:0]       rsp_out_char,
   output logic                              rsp_last,
   // configuration port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [sird_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [sird_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [sird_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   // digit width and divisor width follow from the largest radix
   localparam int DIG_W = (MAX_BASE > 2) ? $clog2(MAX_BASE) : 1;
   localparam int DIV_W = DIG_W + 1;
   localparam int DEPTH = sird_pkg::VALUE_W;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   // ---------------- configuration registers ----------------
   logic [sird_pkg::LEN_W-1:0]      base_len_ff, base_len_in;
   logic [sird_pkg::CSR_DATA_W-1:0] sym_low_ff, sym_low_in;
   logic [sird_pkg::CSR_DATA_W-1:0] sym_high_ff, sym_high_in;
   logic                            csr_write;
   logic [1:0]                      csr_index;
   logic [sird_pkg::SYMS_W-1:0]     symbols;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[4:3];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign symbols    = {sym_high_ff, sym_low_ff};

   always_comb begin
      base_len_in = base_len_ff;
      sym_low_in  = sym_low_ff;
      sym_high_in = sym_high_ff;
      if (csr_write) begin
         case (csr_index)
            sird_pkg::REG_BASE_LEN:     base_len_in = csr_pwdata[sird_pkg::LEN_W-1:0];
            sird_pkg::REG_SYMBOLS_LOW:  sym_low_in  = csr_pwdata;
            sird_pkg::REG_SYMBOLS_HIGH: sym_high_in = csr_pwdata;
            default:                    ; // drop writes past the register list
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         sird_pkg::REG_BASE_LEN:     csr_prdata = sird_pkg::CSR_DATA_W'(base_len_ff);
         sird_pkg::REG_SYMBOLS_LOW:  csr_prdata = sym_low_ff;
         sird_pkg::REG_SYMBOLS_HIGH: csr_prdata = sym_high_ff;
         default:                    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_len_ff <= sird_pkg::BASE_LEN_RESET;
         sym_low_ff  <= sird_pkg::SYMBOLS_LOW_RESET;
         sym_high_ff <= sird_pkg::SYMBOLS_HIGH_RESET;
      end else begin
         base_len_ff <= base_len_in;
         sym_low_ff  <= sym_low_in;
         sym_high_ff <= sym_high_in;
      end
   end

   // ---------------- alphabet check, registered every cycle ----------------
   logic alpha_ok;

   sird_alpha #(
      .MAX_BASE (MAX_BASE)
   ) u_alpha (
      .clock    (clock),
      .base_len (base_len_ff),
      .symbols  (symbols),
      .ok       (alpha_ok)
   );

   // ---------------- shared divider ----------------
   logic                         div_start;
   logic [sird_pkg::VALUE_W-1:0] div_quotient;
   logic [DIG_W-1:0]             div_remainder;
   logic                         div_done;
   logic [sird_pkg::VALUE_W-1:0] mag_ff, mag_in;

   // a valid radix never exceeds MAX_BASE, so DIV_W bits hold it
   sird_div #(
      .DIG_W (DIG_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (mag_ff),
      .divisor   (base_len_ff[DIV_W-1:0]),
      .quotient  (div_quotient),
      .remainder (div_remainder),
      .done      (div_done)
   );

   // ---------------- sequencer ----------------
   sird_pkg::state_type state_ff, state_in;

   logic                         neg_ff, neg_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic [DIG_W-1:0]             stack_ff [DEPTH];
   logic [PTR_W-1:0]             push_ptr;
   logic [PTR_W-1:0]             pop_ptr;
   logic [CNT_W-1:0]             cnt_dec;

   logic                         slot_free;
   logic                         push;
   logic                         load;
   logic [sird_pkg::CHAR_W-1:0]  load_char;
   logic                         load_last;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [sird_pkg::CHAR_W-1:0]  rsp_char_ff, rsp_char_in;
   logic                         rsp_last_ff, rsp_last_in;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign cnt_dec   = cnt_ff - 1'b1;
   assign push_ptr  = cnt_ff[PTR_W-1:0];
   assign pop_ptr   = cnt_dec[PTR_W-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sird_pkg::ST_IDLE: begin
            if (req_valid) state_in = sird_pkg::ST_CHECK;
         end
         sird_pkg::ST_CHECK: begin
            if (!alpha_ok)   state_in = sird_pkg::ST_ERROR;
            else if (neg_ff) state_in = sird_pkg::ST_SIGN;
            else             state_in = sird_pkg::ST_DIV_GO;
         end
         sird_pkg::ST_SIGN: begin
            if (slot_free) state_in = sird_pkg::ST_DIV_GO;
         end
         sird_pkg::ST_DIV_GO: begin
            state_in = sird_pkg::ST_DIV_WAIT;
         end
         sird_pkg::ST_DIV_WAIT: begin
            // keep dividing while quotient remains and the stack has room
            if (div_done) begin
               if (div_quotient != '0 && cnt_ff != CNT_W'(DEPTH - 1))
                  state_in = sird_pkg::ST_DIV_GO;
               else
                  state_in = sird_pkg::ST_EMIT;
            end
         end
         sird_pkg::ST_EMIT: begin
            if (slot_free && cnt_ff == CNT_W'(1)) state_in = sird_pkg::ST_NEWLINE;
         end
         sird_pkg::ST_NEWLINE: begin
            if (slot_free) state_in = sird_pkg::ST_IDLE;
         end
         sird_pkg::ST_ERROR: begin
            if (slot_free) state_in = sird_pkg::ST_NEWLINE;
         end
         default: begin
            state_in = sird_pkg::ST_IDLE;
         end
      endcase
   end

   // control outputs
   always_comb begin
      req_ready = 1'b0;
      div_start = 1'b0;
      push      = 1'b0;
      load      = 1'b0;
      load_char = sird_pkg::CHAR_NUL;
      load_last = 1'b0;
      case (state_ff)
         sird_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         sird_pkg::ST_SIGN: begin
            load      = slot_free;
            load_char = sird_pkg::CHAR_MINUS;
         end
         sird_pkg::ST_DIV_GO: begin
            div_start = 1'b1;
         end
         sird_pkg::ST_DIV_WAIT: begin
            push = div_done;
         end
         sird_pkg::ST_EMIT: begin
            load      = slot_free;
            load_char = sird_pkg::sym_at(symbols, sird_pkg::SYM_IDX_W'(stack_ff[pop_ptr]));
         end
         sird_pkg::ST_NEWLINE: begin
            load      = slot_free;
            load_char = sird_pkg::CHAR_NEWLINE;
            load_last = 1'b1;
         end
         sird_pkg::ST_ERROR: begin
            load      = slot_free;
            load_char = sird_pkg::CHAR_NUL;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // datapath
   always_comb begin
      mag_in = mag_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      if (req_valid && req_ready) begin
         // hold the raw value; the magnitude is formed in the check cycle
         mag_in = req_value;
         neg_in = req_value[sird_pkg::VALUE_W-1];
         cnt_in = '0;
      end else if (state_ff == sird_pkg::ST_CHECK) begin
         if (neg_ff) mag_in = '0 - mag_ff;
      end else if (push) begin
         mag_in = div_quotient;
         cnt_in = cnt_ff + 1'b1;
      end else if (state_ff == sird_pkg::ST_EMIT && load) begin
         cnt_in = cnt_dec;
      end
   end

   // output stage: advance on load, drop on acceptance
   always_comb begin
      rsp_char_in = rsp_char_ff;
      rsp_last_in = rsp_last_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = load_char;
         rsp_last_in  = load_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sird_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      if (push) stack_ff[push_ptr] <= div_remainder;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_char = rsp_char_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

// ----- hdl/sird_checker.sv -----
// ---------------------------------------------------------------------------
// sird_checker
// Port-level checks for the radix digit converter, bound to the top level.
// ---------------------------------------------------------------------------
module sird_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [sird_pkg::CHAR_W-1:0] rsp_out_char,
   input logic                        rsp_last
);

   // a stalled result byte holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_char) && $stable(rsp_last))
      else $error("result changed while stalled");

   // one request at a time: busy right after a request is taken
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // the closing byte of a run is always a newline
   a_last_newline: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_out_char == sird_pkg::CHAR_NEWLINE)
      else $error("last byte is not a newline");

   // reset empties the output stage
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind signed_int_to_radix_digits sird_checker u_sird_checker (.*);

// ----- tb/tb.sv -----
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for signed_int_to_radix_digits. A short table of
// directed requests (decimal and hex extremes, the longest binary string,
// every kind of bad alphabet, a NUL symbol, a write to an unused register)
// is followed by random requests over random alphabets and radixes. Each
// accepted request is expanded into the text bytes it must produce, and every
// byte out of the block is compared in order against that list.
// ---------------------------------------------------------------------------
module tb;

   localparam int CLK_HALF       = 6;
   localparam int RESET_CYCLES   = 11;
   localparam int MAX_BASE       = sird_pkg::MAX_BASE_DEFAULT;
   localparam int N_DIRECTED     = 24;
   localparam int N_PHASES       = 8;
   localparam int BATCH          = 25;
   // sized for the worst case per request: sign and 32 binary digits
   localparam int SETTLE_CYCLES  = 240;
   localparam int MAX_GAP        = 60;
   localparam int MAX_PRINTS     = 40;
   localparam int TIMEOUT_CYCLES = 1_500_000;

   localparam int AW = sird_pkg::CSR_ADDR_W;
   localparam int DW = sird_pkg::CSR_DATA_W;
   localparam int CW = sird_pkg::CHAR_W;
   localparam int LW = sird_pkg::LEN_W;
   localparam int VW = sird_pkg::VALUE_W;

   localparam logic [63:0] DEC_LOW  = sird_pkg::SYMBOLS_LOW_RESET;
   localparam logic [63:0] DEC_HIGH = sird_pkg::SYMBOLS_HIGH_RESET;

   localparam logic [1:0] REG_UNUSED = 2'd3;
   localparam logic [AW-1:0] ADDR_BASE_LEN     = {sird_pkg::REG_BASE_LEN, 3'b000};
   localparam logic [AW-1:0] ADDR_SYMBOLS_LOW  = {sird_pkg::REG_SYMBOLS_LOW, 3'b000};
   localparam logic [AW-1:0] ADDR_SYMBOLS_HIGH = {sird_pkg::REG_SYMBOLS_HIGH, 3'b000};
   localparam logic [AW-1:0] ADDR_UNUSED       = {REG_UNUSED, 3'b000};

   // hex alphabet "0123456789abcdef"
   localparam logic [63:0] HEX_LOW  = 64'h3736_3534_3332_3130;
   localparam logic [63:0] HEX_HIGH = 64'h6665_6463_6261_3938;

   typedef enum {CHK_MODEL, CHK_TEXT, CHK_ERROR} check_kind_type;
   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_kind_type;

   typedef struct packed {
      logic [CW-1:0] ch;
      logic          last;
   } text_beat_type;

   typedef struct {
      bit             reconfig;
      bit             junk;
      logic [LW-1:0]  len;
      logic [63:0]    lo;
      logic [63:0]    hi;
      logic [VW-1:0]  value;
      check_kind_type check;
      string          text;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid   = 1'b0;
   logic              req_ready;
   logic [VW-1:0]     req_value   = '0;
   logic              rsp_valid;
   logic              rsp_ready   = 1'b0;
   logic [CW-1:0]     rsp_out_char;
   logic              rsp_last;
   logic              csr_psel    = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite  = 1'b0;
   logic [AW-1:0]     csr_paddr   = '0;
   logic [DW-1:0]     csr_pwdata  = '0;
   logic [DW-1:0]     csr_prdata;
   logic              csr_pready;

   // mirror of the block's registers, as the predictor sees them
   logic [LW-1:0]     cfg_len  = sird_pkg::BASE_LEN_RESET;
   logic [2*64-1:0]   cfg_syms = {DEC_HIGH, DEC_LOW};

   text_beat_type  pending_text[$];
   idle_kind_type  idle_mode = IDLE_NONE;
   int             mismatches = 0;
   int             requests_sent = 0;
   int             bad_alphabet_requests = 0;
   int             beats_checked = 0;
   int             settings_loaded = 0;

   // Directed requests. Rows with reconfig load len/lo/hi first; typed text
   // omits the trailing newline, which is always appended.
   stim_row_type directed_rows [N_DIRECTED] = '{
      // reset alphabet, radix 10
      '{1'b0, 1'b0, 5'd10, DEC_LOW, DEC_HIGH,
        32'h0000_0000, CHK_TEXT, "0"},
      '{1'b0, 1'b0, 5'd10, DEC_LOW, DEC_HIGH,
        32'h0000_0001, CHK_TEXT, "1"},
      '{1'b0, 1'b0, 5'd10, DEC_LOW, DEC_HIGH,
        32'hFFFF_FFFF, CHK_TEXT, "-1"},
      '{1'b0, 1'b0, 5'd10, DEC_LOW, DEC_HIGH,
        32'h7FFF_FFFF, CHK_TEXT, "2147483647"},
      '{1'b0, 1'b0, 5'd10, DEC_LOW, DEC_HIGH,
        32'h8000_0000, CHK_TEXT, "-2147483648"},
      '{1'b0, 1'b0, 5'd10, DEC_LOW, DEC_HIGH,
        32'd1234567890, CHK_MODEL, ""},
      // radix 16
      '{1'b1, 1'b0, 5'd16, HEX_LOW, HEX_HIGH,
        32'hFFFF_FFFF, CHK_TEXT, "-1"},
      '{1'b0, 1'b0, 5'd16, HEX_LOW, HEX_HIGH,
        32'h8000_0000, CHK_TEXT, "-80000000"},
      '{1'b0, 1'b0, 5'd16, HEX_LOW, HEX_HIGH,
        32'h7FFF_FFFF, CHK_TEXT, "7fffffff"},
      '{1'b0, 1'b0, 5'd16, HEX_LOW, HEX_HIGH,
        32'h5A5A_A5A5, CHK_MODEL, ""},
      // radix 2; symbols past the length are junk and must be ignored
      '{1'b1, 1'b0, 5'd2, 64'h2B2D_2B2D_2B2D_3130, 64'h2020_2020_2020_2020,
        32'h8000_0000, CHK_MODEL, ""},
      '{1'b0, 1'b0, 5'd2, 64'h2B2D_2B2D_2B2D_3130, 64'h2020_2020_2020_2020,
        32'h7FFF_FFFF, CHK_MODEL, ""},
      // lengths out of range
      '{1'b1, 1'b0, 5'd1, DEC_LOW, DEC_HIGH,
        32'd5, CHK_ERROR, ""},
      '{1'b1, 1'b0, 5'd0, DEC_LOW, DEC_HIGH,
        32'hFFFF_FFF9, CHK_ERROR, ""},
      '{1'b1, 1'b0, 5'd17, HEX_LOW, HEX_HIGH,
        32'd42, CHK_ERROR, ""},
      '{1'b1, 1'b0, 5'd31, HEX_LOW, HEX_HIGH,
        32'd0, CHK_ERROR, ""},
      // forbidden symbols: plus as the last digit, minus as the first
      '{1'b1, 1'b0, 5'd10, DEC_LOW, 64'h0000_0000_0000_2B38,
        32'd99, CHK_ERROR, ""},
      '{1'b1, 1'b0, 5'd10, 64'h3736_3534_3332_312D, DEC_HIGH,
        32'd99, CHK_ERROR, ""},
      // space as symbol 15, then symbol 15 repeating symbol 0
      '{1'b1, 1'b0, 5'd16, HEX_LOW, 64'h2065_6463_6261_3938,
        32'd99, CHK_ERROR, ""},
      '{1'b1, 1'b0, 5'd16, HEX_LOW, 64'h3065_6463_6261_3938,
        32'hFFFF_FF9D, CHK_ERROR, ""},
      // NUL is an ordinary digit symbol
      '{1'b1, 1'b0, 5'd3, 64'h0000_0000_0062_6100, 64'h0,
        32'd9, CHK_MODEL, ""},
      '{1'b0, 1'b0, 5'd3, 64'h0000_0000_0062_6100, 64'h0,
        32'd0, CHK_MODEL, ""},
      // back to decimal, then a write to the unused slot that must not stick
      '{1'b1, 1'b1, 5'd10, DEC_LOW, DEC_HIGH,
        32'hFFFF_FECF, CHK_TEXT, "-305"},
      // top byte values as symbols
      '{1'b1, 1'b0, 5'd16, 64'hF7F6_F5F4_F3F2_F1F0, 64'hFFFE_FDFC_FBFA_F9F8,
        32'h8000_0001, CHK_MODEL, ""}
   };

   signed_int_to_radix_digits dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_char (rsp_out_char),
      .rsp_last     (rsp_last),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Text predictor
   // ---------------------------------------------------------------------
   function automatic logic [CW-1:0] symbol_of(input int unsigned k);
      return cfg_syms[8*k +: 8];
   endfunction

   // A usable alphabet has 2..MAX_BASE symbols, none of them a sign or a
   // space, and no symbol twice.
   function automatic bit alphabet_valid();
      logic [CW-1:0] s;
      if (cfg_len < 2 || cfg_len > MAX_BASE) return 1'b0;
      for (int a = 0; a < cfg_len; a++) begin
         s = symbol_of(a);
         if (s == sird_pkg::CHAR_PLUS || s == sird_pkg::CHAR_MINUS ||
             s == sird_pkg::CHAR_SPACE) return 1'b0;
         for (int b = a + 1; b < cfg_len; b++)
            if (symbol_of(b) == s) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void push_beat(input logic [CW-1:0] ch, input logic last);
      text_beat_type beat;
      beat.ch   = ch;
      beat.last = last;
      pending_text.push_back(beat);
   endfunction

   function automatic void push_error_text();
      push_beat(sird_pkg::CHAR_NUL, 1'b0);
      push_beat(sird_pkg::CHAR_NEWLINE, 1'b1);
   endfunction

   // Expand one value into its text under the mirrored alphabet. The
   // magnitude is taken modulo 2^32, so the most negative value works too.
   function automatic void render_value(input logic [VW-1:0] raw);
      logic [VW-1:0] mag;
      int unsigned   radix;
      int unsigned   digits[$];
      if (!alphabet_valid()) begin
         push_error_text();
         return;
      end
      radix = cfg_len;
      if (raw[VW-1]) begin
         push_beat(sird_pkg::CHAR_MINUS, 1'b0);
         mag = -raw;
      end else begin
         mag = raw;
      end
      do begin
         digits.push_front(mag % radix);
         mag = mag / radix;
      end while (mag != 0);
      foreach (digits[i]) push_beat(symbol_of(digits[i]), 1'b0);
      push_beat(sird_pkg::CHAR_NEWLINE, 1'b1);
   endfunction

   function automatic void record_expectation(input logic [VW-1:0] raw,
                                              input check_kind_type check,
                                              input string text);
      if (!alphabet_valid()) bad_alphabet_requests++;
      case (check)
         CHK_TEXT: begin
            for (int i = 0; i < text.len(); i++) push_beat(text[i], 1'b0);
            push_beat(sird_pkg::CHAR_NEWLINE, 1'b1);
         end
         CHK_ERROR: push_error_text();
         default: render_value(raw);
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Idle patterns
   // ---------------------------------------------------------------------
   function automatic int sender_idle_pct();
      case (idle_mode)
         IDLE_SENDER: return 71;
         IDLE_BOTH:   return 35;
         default:     return 0;
      endcase
   endfunction

   function automatic int receiver_stall_pct();
      case (idle_mode)
         IDLE_RECEIVER: return 71;
         IDLE_BOTH:     return 35;
         default:       return 0;
      endcase
   endfunction

   function automatic int idle_gap();
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct()) gap++;
      return gap;
   endfunction

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------
   // APB write: setup, then access until pready; then drop psel.
   task automatic csr_write(input logic [AW-1:0] addr,
                            input logic [DW-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Load all three registers and update the mirror; only the low five bits
   // of the length word are kept.
   task automatic load_alphabet(input logic [63:0] len_word,
                                input logic [63:0] lo,
                                input logic [63:0] hi);
      csr_write(ADDR_BASE_LEN, len_word);
      csr_write(ADDR_SYMBOLS_LOW, lo);
      csr_write(ADDR_SYMBOLS_HIGH, hi);
      cfg_len  = len_word[LW-1:0];
      cfg_syms = {hi, lo};
      settings_loaded++;
   endtask

   // Offer one request and hold it until taken. With hold set, valid stays up
   // for the next request; otherwise drop it.
   task automatic send_request(input logic [VW-1:0] value,
                               input check_kind_type check,
                               input string text,
                               input bit hold);
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
      record_expectation(value, check, text);
      requests_sent++;
      if (!hold) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      while (pending_text.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Random stimulus helpers
   // ---------------------------------------------------------------------
   // Half full 32-bit noise, the rest extremes, small values and shifted magnitudes.
   function automatic logic [VW-1:0] draw_value();
      case ($urandom_range(7))
         0: return 32'($urandom_range(40)) - 32'd20;
         1: begin
            case ($urandom_range(3))
               0:       return 32'h8000_0000;
               1:       return 32'h7FFF_FFFF;
               2:       return 32'hFFFF_FFFF;
               default: return 32'h0;
            endcase
         end
         2: return $urandom >> $urandom_range(31);
         3: return -($urandom >> $urandom_range(31));
         default: return $urandom;
      endcase
   endfunction

   // Sixteen distinct legal symbols; most settings are usable radixes, the
   // rest break the length, plant a forbidden symbol or repeat one.
   task automatic draw_alphabet(output logic [LW-1:0] len,
                                output logic [2*64-1:0] syms);
      bit            taken [256];
      logic [CW-1:0] c;
      int            pick;
      int            a;
      int            b;
      for (int k = 0; k < sird_pkg::SYM_COUNT; k++) begin
         do c = 8'($urandom_range(255));
         while (taken[c] || c == sird_pkg::CHAR_PLUS || c == sird_pkg::CHAR_MINUS ||
                c == sird_pkg::CHAR_SPACE);
         taken[c] = 1'b1;
         syms[8*k +: 8] = c;
      end
      pick = $urandom_range(99);
      if (pick < 12)       len = 5'd2;
      else if (pick < 24)  len = 5'd16;
      else if (pick < 70)  len = 5'($urandom_range(3, 15));
      else if (pick < 78)  len = $urandom_range(1) ? 5'($urandom_range(1))
                                                    : 5'($urandom_range(17, 31));
      else begin
         len = 5'($urandom_range(2, 16));
         if (pick < 89) begin
            b = $urandom_range(0, len - 1);
            case ($urandom_range(2))
               0:       syms[8*b +: 8] = sird_pkg::CHAR_PLUS;
               1:       syms[8*b +: 8] = sird_pkg::CHAR_MINUS;
               default: syms[8*b +: 8] = sird_pkg::CHAR_SPACE;
            endcase
         end else begin
            b = $urandom_range(1, len - 1);
            a = $urandom_range(0, b - 1);
            syms[8*b +: 8] = syms[8*a +: 8];
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Result side: stall at random and check every byte in order
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      text_beat_type want;
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct());
      if (!reset && rsp_valid && rsp_ready) begin
         beats_checked++;
         if (pending_text.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_PRINTS)
               $display("%0t: byte 0x%02h last %0b arrived with nothing expected",
                        $time, rsp_out_char, rsp_last);
         end else begin
            want = pending_text.pop_front();
            if (rsp_out_char !== want.ch || rsp_last !== want.last) begin
               mismatches++;
               if (mismatches <= MAX_PRINTS)
                  $display("%0t: expected byte 0x%02h last %0b, got 0x%02h last %0b",
                           $time, want.ch, want.last, rsp_out_char, rsp_last);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      logic [LW-1:0]     len;
      logic [2*64-1:0]   syms;
      logic [63:0]       len_word;
      logic [63:0]       noise;
      int                gap;
      bit                next_reconfig;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table back to back; drain before every reload.
      idle_mode = IDLE_NONE;
      for (int r = 0; r < N_DIRECTED; r++) begin
         if (directed_rows[r].reconfig) begin
            wait_drained();
            load_alphabet({59'd0, directed_rows[r].len},
                          directed_rows[r].lo, directed_rows[r].hi);
            // aliasing onto base_len would turn the next request into binary
            if (directed_rows[r].junk)
               csr_write(ADDR_UNUSED, 64'h2D2D_2D2D_2D2D_2D02);
         end
         next_reconfig = (r == N_DIRECTED - 1) ? 1'b1 : directed_rows[r + 1].reconfig;
         send_request(directed_rows[r].value, directed_rows[r].check,
                      directed_rows[r].text, !next_reconfig);
      end

      // Random phases: a fresh alphabet each, idle pattern cycling through
      // none, sender, receiver and both.
      for (int p = 0; p < N_PHASES; p++) begin
         wait_drained();
         draw_alphabet(len, syms);
         noise    = {$urandom, $urandom};
         len_word = {noise[63:LW], len};
         load_alphabet(len_word, syms[63:0], syms[127:64]);
         if ($urandom_range(3) == 0) csr_write(ADDR_UNUSED, {$urandom, $urandom});
         idle_mode = idle_kind_type'(p % 4);
         for (int i = 0; i < BATCH; i++) begin
            gap = idle_gap();
            send_request(draw_value(), CHK_MODEL, "", (i < BATCH - 1) && (gap == 0));
            repeat (gap) @(posedge clock);
         end
      end

      // Let the last text drain, then give any stray bytes time to show.
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Converted %0d values (%0d under bad alphabets) across %0d alphabet loads,",
               requests_sent, bad_alphabet_requests, settings_loaded);
      $display("checking %0d text bytes under four idle patterns.", beats_checked);
      if (mismatches == 0) begin
         $display("[signed_int_to_radix_digits] OK");
      end else begin
         $display("[signed_int_to_radix_digits] ERROR");
      end
      $finish;
   end

   // Hard stop in case the block hangs.
   initial begin
      #(2 * CLK_HALF * TIMEOUT_CYCLES);
      $display("[signed_int_to_radix_digits] ERROR");
      $finish;
   end

endmodule
